// File: rtl/mra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mra_pkg;

    localparam int DATE_W  = 27;
    localparam int SEC_W   = 17;
    localparam int ANGLE_W = 23;

    // quotient by 625 from a 23-bit value: (x * RECIP_625) >> 32, low by at most one
    localparam logic [22:0] RECIP_625 = 23'd6871947;
    localparam logic [10:0] DIV_625   = 11'd625;

    // quotient by 100, exact for values below 43690: (x * RECIP_100) >> 19
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [6:0]  DIV_100   = 7'd100;

    localparam logic [11:0] RATE_COMMON = 12'd3550;
    localparam logic [11:0] RATE_LEAP   = 12'd3540;
    localparam logic [16:0] SEC_PER_DAY = 17'd86400;
    // day of year of 23 september in a common year
    localparam logic [8:0]  DOY_SEP23   = 9'd266;

    typedef struct packed {
        logic        leap;
        logic [13:0] mmdd;
        logic [16:0] secs;
    } t_date_fields;

    typedef struct packed {
        logic        ok;
        logic        leap;
        logic [3:0]  mm;
        logic [6:0]  dd;
        logic [16:0] secs;
    } t_md_fields;

    function automatic logic [8:0] days_before(input logic [3:0] mm);
        logic [8:0] d;
        case (mm)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mra_date_split.sv
`timescale 1ns / 1ps
`default_nettype none

// splits yyyymmdd into leap flag and mmdd, four stages
module mra_date_split
    import mra_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [DATE_W-1:0]  i_packed_date,
    input  wire logic [SEC_W-1:0]   i_seconds_of_day,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output t_date_fields            o_fields
);

    logic r_v_a, r_v_b, r_v_c, r_v_d;
    logic w_en_a, w_en_b, w_en_c, w_en_d;

    logic [22:0]      r_a_x;
    logic [3:0]       r_a_lo;
    logic [16:0]      r_a_secs;
    logic [13:0]      r_b_q0;
    logic [22:0]      r_b_x;
    logic [3:0]       r_b_lo;
    logic [16:0]      r_b_secs;
    logic [1:0]       r_c_q0lo;
    logic [10:0]      r_c_rem0;
    logic [3:0]       r_c_lo;
    logic [16:0]      r_c_secs;
    t_date_fields     r_d;

    logic [45:0]      n_prod;
    logic [23:0]      n_q625;
    logic [23:0]      n_rem0;
    logic             n_corr;
    logic [1:0]       n_ylo;
    logic [10:0]      n_rem;
    t_date_fields     n_d;

    assign w_en_d  = !r_v_d || !i_stall;
    assign w_en_c  = !r_v_c || w_en_d;
    assign w_en_b  = !r_v_b || w_en_c;
    assign w_en_a  = !r_v_a || w_en_b;
    assign o_stall = !w_en_a;
    assign o_valid = r_v_d;
    assign o_fields = r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
        end else begin
            if (w_en_a) r_v_a <= i_valid;
            if (w_en_b) r_v_b <= r_v_a;
            if (w_en_c) r_v_c <= r_v_b;
            if (w_en_d) r_v_d <= r_v_c;
        end
    end

    // date / 10000 = (date >> 4) / 625
    always_comb begin
        n_prod = 46'(r_a_x) * 46'(RECIP_625);
        n_q625 = 24'(r_b_q0) * 24'(DIV_625);
        n_rem0 = 24'(r_b_x) - n_q625;
        n_corr = (r_c_rem0 >= DIV_625);
        n_ylo  = r_c_q0lo + 2'(n_corr);
        n_rem  = n_corr ? (r_c_rem0 - DIV_625) : r_c_rem0;
        n_d.leap = (n_ylo == 2'd0);
        n_d.mmdd = {n_rem[9:0], r_c_lo};
        n_d.secs = r_c_secs;
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_x    <= i_packed_date[26:4];
            r_a_lo   <= i_packed_date[3:0];
            r_a_secs <= i_seconds_of_day;
        end
        if (w_en_b) begin
            r_b_q0   <= n_prod[45:32];
            r_b_x    <= r_a_x;
            r_b_lo   <= r_a_lo;
            r_b_secs <= r_a_secs;
        end
        if (w_en_c) begin
            r_c_q0lo <= r_b_q0[1:0];
            r_c_rem0 <= n_rem0[10:0];
            r_c_lo   <= r_b_lo;
            r_c_secs <= r_b_secs;
        end
        if (w_en_d) begin
            r_d <= n_d;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mra_md_split.sv
`timescale 1ns / 1ps
`default_nettype none

// splits mmdd into month and day, two stages
module mra_md_split
    import mra_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire t_date_fields  i_fields,
    output logic               o_valid,
    input  wire logic          i_stall,
    output t_md_fields         o_fields
);

    logic r_v_e, r_v_f;
    logic w_en_e, w_en_f;

    logic [6:0]   r_e_mm;
    logic [13:0]  r_e_mmdd;
    logic         r_e_leap;
    logic [16:0]  r_e_secs;
    t_md_fields   r_f;

    logic [26:0]  n_mm_prod;
    logic [13:0]  n_mm100;
    logic [13:0]  n_dd;
    t_md_fields   n_f;

    assign w_en_f  = !r_v_f || !i_stall;
    assign w_en_e  = !r_v_e || w_en_f;
    assign o_stall = !w_en_e;
    assign o_valid = r_v_f;
    assign o_fields = r_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_e <= 1'b0;
            r_v_f <= 1'b0;
        end else begin
            if (w_en_e) r_v_e <= i_valid;
            if (w_en_f) r_v_f <= r_v_e;
        end
    end

    always_comb begin
        n_mm_prod = 27'(i_fields.mmdd) * 27'(RECIP_100);
        n_mm100   = 14'(r_e_mm) * 14'(DIV_100);
        n_dd      = r_e_mmdd - n_mm100;
        n_f.ok    = (r_e_mm >= 7'd1) && (r_e_mm <= 7'd12);
        n_f.leap  = r_e_leap;
        n_f.mm    = r_e_mm[3:0];
        n_f.dd    = n_dd[6:0];
        n_f.secs  = r_e_secs;
    end

    always_ff @(posedge i_clk) begin
        if (w_en_e) begin
            r_e_mm   <= n_mm_prod[25:19];
            r_e_mmdd <= i_fields.mmdd;
            r_e_leap <= i_fields.leap;
            r_e_secs <= i_fields.secs;
        end
        if (w_en_f) begin
            r_f <= n_f;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mra_angle.sv
`timescale 1ns / 1ps
`default_nettype none

// day offset, rate product and time term, three stages incl. output register
module mra_angle
    import mra_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire t_md_fields                i_fields,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic signed [ANGLE_W-1:0]      o_meridian_arcsec,
    output logic                           o_date_ok
);

    logic r_v_g, r_v_h, r_v_i;
    logic w_en_g, w_en_h, w_en_i;

    logic signed [9:0]          r_g_offset;
    logic                       r_g_leap;
    logic signed [21:0]         r_g_tterm;
    logic                       r_g_ok;
    logic signed [22:0]         r_h_prod;
    logic signed [21:0]         r_h_tterm;
    logic                       r_h_ok;
    logic signed [ANGLE_W-1:0]  r_i_angle;
    logic                       r_i_ok;

    logic [8:0]                 n_doy;
    logic [8:0]                 n_ref;
    logic signed [9:0]          n_offset;
    logic signed [17:0]         n_tdiff;
    logic signed [21:0]         n_tdiff_ext;
    logic signed [21:0]         n_tterm;
    logic [11:0]                n_rate;
    logic signed [22:0]         n_prod;
    logic signed [ANGLE_W-1:0]  n_angle;

    assign w_en_i  = !r_v_i || !i_stall;
    assign w_en_h  = !r_v_h || w_en_i;
    assign w_en_g  = !r_v_g || w_en_h;
    assign o_stall = !w_en_g;
    assign o_valid = r_v_i;
    assign o_meridian_arcsec = r_i_angle;
    assign o_date_ok = r_i_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_g <= 1'b0;
            r_v_h <= 1'b0;
            r_v_i <= 1'b0;
        end else begin
            if (w_en_g) r_v_g <= i_valid;
            if (w_en_h) r_v_h <= r_v_g;
            if (w_en_i) r_v_i <= r_v_h;
        end
    end

    always_comb begin
        // day of year, with the leap day after february
        n_doy = days_before(i_fields.mm) + 9'(i_fields.dd)
              + 9'(i_fields.leap && (i_fields.mm > 4'd2));
        n_ref = DOY_SEP23 + 9'(i_fields.leap);
        n_offset = $signed({1'b0, n_doy}) - $signed({1'b0, n_ref});
        // (86400 - secs) * 15 as x*16 - x
        n_tdiff = $signed({1'b0, SEC_PER_DAY}) - $signed({1'b0, i_fields.secs});
        n_tdiff_ext = {{4{n_tdiff[17]}}, n_tdiff};
        n_tterm = (n_tdiff_ext <<< 4) - n_tdiff_ext;

        n_rate = r_g_leap ? RATE_LEAP : RATE_COMMON;
        n_prod = $signed({{13{r_g_offset[9]}}, r_g_offset}) * $signed({11'b0, n_rate});

        n_angle = r_h_prod - $signed({r_h_tterm[21], r_h_tterm});
    end

    always_ff @(posedge i_clk) begin
        if (w_en_g) begin
            r_g_offset <= n_offset;
            r_g_leap   <= i_fields.leap;
            r_g_tterm  <= n_tterm;
            r_g_ok     <= i_fields.ok;
        end
        if (w_en_h) begin
            r_h_prod  <= n_prod;
            r_h_tterm <= r_g_tterm;
            r_h_ok    <= r_g_ok;
        end
        if (w_en_i) begin
            r_i_angle <= r_h_ok ? n_angle : '0;
            r_i_ok    <= r_h_ok;
        end
    end

endmodule

`default_nettype wire

// File: rtl/meridian_right_ascension_top.sv
// meridian right ascension from a packed date and a time of day
//
// input channel: i_valid / o_stall with i_packed_date (decimal yyyymmdd) and
//   i_seconds_of_day; a request is taken at a clock edge with i_valid high
//   and o_stall low
// output channel: o_valid / i_stall with o_meridian_arcsec (signed
//   arcseconds from 23 september midnight) and o_date_ok; a result is taken
//   at an edge with o_valid high and i_stall low
// throughput: one request per cycle while the receiver does not stall, set by
//   the nine-stage pipeline (divide by 10000 in four stages, month/day split
//   in two, angle in three)
// a month outside 1..12 gives o_date_ok low and an angle of zero
// reset (synchronous, active low) drops every valid bit; results in flight
//   are lost and o_valid is low in the cycle after reset
// when the receiver stalls, the output holds; stages behind it keep filling
//   bubbles, and o_stall rises only once every stage holds a request
`timescale 1ns / 1ps
`default_nettype none

module meridian_right_ascension_top
    import mra_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [DATE_W-1:0]         i_packed_date,
    input  wire logic [SEC_W-1:0]          i_seconds_of_day,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic signed [ANGLE_W-1:0]      o_meridian_arcsec,
    output logic                           o_date_ok
);

    // date split -> month/day split
    logic          w_ds_valid;
    logic          w_ds_stall;
    t_date_fields  w_ds_fields;

    // month/day split -> angle
    logic          w_md_valid;
    logic          w_md_stall;
    t_md_fields    w_md_fields;

    // stages a..d: year quotient, leap flag and mmdd
    mra_date_split u_date_split (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_packed_date    (i_packed_date),
        .i_seconds_of_day (i_seconds_of_day),
        .o_valid          (w_ds_valid),
        .i_stall          (w_ds_stall),
        .o_fields         (w_ds_fields)
    );

    // stages e..f: month, day and month range check
    mra_md_split u_md_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_ds_valid),
        .o_stall  (w_ds_stall),
        .i_fields (w_ds_fields),
        .o_valid  (w_md_valid),
        .i_stall  (w_md_stall),
        .o_fields (w_md_fields)
    );

    // stages g..i: day offset, rate product, time term, output register
    mra_angle u_angle (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_md_valid),
        .o_stall           (w_md_stall),
        .i_fields          (w_md_fields),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_meridian_arcsec (o_meridian_arcsec),
        .o_date_ok         (o_date_ok)
    );

endmodule

`default_nettype wire

// File: rtl/mra_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mra_checker
    import mra_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      o_stall,
    input  wire logic [DATE_W-1:0]         i_packed_date,
    input  wire logic [SEC_W-1:0]          i_seconds_of_day,
    input  wire logic                      o_valid,
    input  wire logic                      i_stall,
    input  wire logic signed [ANGLE_W-1:0] o_meridian_arcsec,
    input  wire logic                      o_date_ok
);

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a bad month always carries a zero angle
    a_bad_month_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_date_ok) |-> (o_meridian_arcsec == '0))
        else $error("nonzero angle with bad month");

    // input is held off only when a result is waiting on a stalled receiver
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output free");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_meridian_arcsec) && $stable(o_date_ok)))
        else $error("stalled result changed");

endmodule

bind meridian_right_ascension_top mra_checker u_mra_checker (.*);

`default_nettype wire
